// ----- hdl/ilp_pkg.sv -----
// shared types, codes and constant tables of the integer literal parser
`default_nettype none
package ilp_pkg;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FORMAT = 2'd1,
        ST_RANGE  = 2'd2
    } status_t;

    // finished literal handed from the parser to the scaling stages
    typedef struct packed {
        logic [63:0] mag;
        status_t     status;
        logic        is_dec;
        logic        neg;
        logic [2:0]  sfx;
        logic        wide;
    } fin_t;

    localparam logic [63:0] LIM_NARROW_POS = 64'h0000_0000_7FFF_FFFF;
    localparam logic [63:0] LIM_NARROW_NEG = 64'h0000_0000_8000_0000;
    localparam logic [63:0] LIM_WIDE_POS   = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] LIM_WIDE_NEG   = 64'h8000_0000_0000_0000;

    localparam logic [63:0] FK = 64'd1024;
    localparam logic [63:0] FD = 64'd1000;

    // suffix code: 0 none, 1 k, 2 K, 3 m, 4 M, 5 g, 6 G
    localparam logic [63:0] FACTOR_TAB [8] = '{
        64'd0, FK, FD, FK * FK, FD * FD, FK * FK * FK, FD * FD * FD, 64'd0
    };

    // indexed by {wide, negative}
    localparam logic [63:0] DEC_LIM [4] = '{
        LIM_NARROW_POS, LIM_NARROW_NEG, LIM_WIDE_POS, LIM_WIDE_NEG
    };

    localparam logic [63:0] DEC_LIM10 [4] = '{
        LIM_NARROW_POS / 64'd10, LIM_NARROW_NEG / 64'd10,
        LIM_WIDE_POS / 64'd10, LIM_WIDE_NEG / 64'd10
    };

    // largest magnitude that still fits after the suffix multiply
    localparam logic [63:0] SFX_LIM [4][8] = '{
        '{LIM_NARROW_POS, LIM_NARROW_POS / FK, LIM_NARROW_POS / FD,
          LIM_NARROW_POS / (FK * FK), LIM_NARROW_POS / (FD * FD),
          LIM_NARROW_POS / (FK * FK * FK), LIM_NARROW_POS / (FD * FD * FD),
          LIM_NARROW_POS},
        '{LIM_NARROW_NEG, LIM_NARROW_NEG / FK, LIM_NARROW_NEG / FD,
          LIM_NARROW_NEG / (FK * FK), LIM_NARROW_NEG / (FD * FD),
          LIM_NARROW_NEG / (FK * FK * FK), LIM_NARROW_NEG / (FD * FD * FD),
          LIM_NARROW_NEG},
        '{LIM_WIDE_POS, LIM_WIDE_POS / FK, LIM_WIDE_POS / FD,
          LIM_WIDE_POS / (FK * FK), LIM_WIDE_POS / (FD * FD),
          LIM_WIDE_POS / (FK * FK * FK), LIM_WIDE_POS / (FD * FD * FD),
          LIM_WIDE_POS},
        '{LIM_WIDE_NEG, LIM_WIDE_NEG / FK, LIM_WIDE_NEG / FD,
          LIM_WIDE_NEG / (FK * FK), LIM_WIDE_NEG / (FD * FD),
          LIM_WIDE_NEG / (FK * FK * FK), LIM_WIDE_NEG / (FD * FD * FD),
          LIM_WIDE_NEG}
    };

endpackage
`default_nettype wire

// ----- hdl/ilp_parse.sv -----
// input register and per-character parser state machine
`default_nettype none
module ilp_parse (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         wide_mode,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [7:0]   s_tdata,
    input  wire logic         s_tlast,
    output logic              fin_valid,
    input  wire logic         fin_ready,
    output ilp_pkg::fin_t     fin
);

    typedef enum logic [2:0] {
        PH_LEAD       = 3'd0,
        PH_ZERO       = 3'd1,
        PH_HEX_EMPTY  = 3'd2,
        PH_SIGN_EMPTY = 3'd3,
        PH_BODY       = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        RX_DEC = 2'd0,
        RX_OCT = 2'd1,
        RX_HEX = 2'd2
    } radix_t;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF_HEX = 8'h66;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_X     = 8'h78;

    localparam logic [2:0] SFX_NONE = 3'd0;

    function automatic logic [2:0] suffix_code(input logic [7:0] c);
        logic [2:0] r;
        case (c)
            8'h6B:   r = 3'd1;  // k
            8'h4B:   r = 3'd2;  // K
            8'h6D:   r = 3'd3;  // m
            8'h4D:   r = 3'd4;  // M
            8'h67:   r = 3'd5;  // g
            8'h47:   r = 3'd6;  // G
            default: r = SFX_NONE;
        endcase
        return r;
    endfunction

    // input register
    logic       i_valid_reg;
    logic [7:0] i_char_reg;
    logic       i_last_reg;

    // parser state
    phase_t           phase_reg, phase_next;
    logic [63:0]      acc_reg, acc_next;
    logic             neg_reg, neg_next;
    radix_t           radix_reg, radix_next;
    logic [4:0]       hcnt_reg, hcnt_next;
    logic [2:0]       sfx_reg, sfx_next;
    logic             space_reg, space_next;
    logic             nz_reg, nz_next;
    ilp_pkg::status_t err_reg, err_next;

    logic          f_valid_reg;
    ilp_pkg::fin_t f_reg, f_next;

    logic proc;
    logic fin_free;

    assign fin_free  = !f_valid_reg || fin_ready;
    assign proc      = i_valid_reg && (!i_last_reg || fin_free);
    assign s_tready  = !i_valid_reg || proc;
    assign fin_valid = f_valid_reg;
    assign fin       = f_reg;

    // character classes and digit value
    logic       is_blank;
    logic [3:0] dval;
    logic       is_dec_digit;
    logic       is_hex_letter;

    always_comb begin
        is_blank = (i_char_reg == CH_SPACE) ||
                   (i_char_reg >= CH_TAB && i_char_reg <= CH_CR);
        is_dec_digit  = (i_char_reg >= CH_ZERO && i_char_reg <= CH_NINE);
        is_hex_letter = 1'b0;
        dval = 4'd0;
        if (is_dec_digit) begin
            dval = 4'(i_char_reg - CH_ZERO);
        end else if (i_char_reg >= CH_LA && i_char_reg <= CH_LF_HEX) begin
            is_hex_letter = 1'b1;
            dval = 4'(i_char_reg - CH_LA + 8'd10);
        end else if (i_char_reg >= CH_UA && i_char_reg <= CH_UF) begin
            is_hex_letter = 1'b1;
            dval = 4'(i_char_reg - CH_UA + 8'd10);
        end
    end

    // one body character under a given radix
    radix_t           body_radix;
    logic             body_en;
    logic             dok;
    logic [2:0]       sc;
    logic [1:0]       lim_idx;
    logic [63:0]      acc10;
    logic [4:0]       hcnt_inc;
    logic             nz_b;
    logic [63:0]      b_acc;
    logic [4:0]       b_hcnt;
    logic [2:0]       b_sfx;
    logic             b_nz;
    ilp_pkg::status_t b_err;

    always_comb begin
        sc      = suffix_code(i_char_reg);
        lim_idx = {wide_mode, neg_reg};
        acc10   = (acc_reg << 3) + (acc_reg << 1);
        nz_b    = nz_reg || (dval != 4'd0);
        hcnt_inc = hcnt_reg + 5'd1;
        case (body_radix)
            RX_HEX:  dok = is_dec_digit || is_hex_letter;
            RX_OCT:  dok = is_dec_digit && (dval < 4'd8);
            default: dok = is_dec_digit;
        endcase
        b_acc  = acc_reg;
        b_hcnt = hcnt_reg;
        b_sfx  = sfx_reg;
        b_nz   = nz_reg;
        b_err  = err_reg;
        if (sfx_reg != SFX_NONE) begin
            b_err = ilp_pkg::ST_FORMAT;
        end else if (body_radix == RX_DEC && sc != SFX_NONE) begin
            b_sfx = sc;
        end else if (!dok) begin
            b_err = ilp_pkg::ST_FORMAT;
        end else begin
            b_nz = nz_b;
            case (body_radix)
                RX_OCT: begin
                    b_acc = (acc_reg << 3) + 64'(dval);
                end
                RX_HEX: begin
                    b_acc = {acc_reg[59:0], dval};
                    if (nz_b) begin
                        b_hcnt = hcnt_inc;
                        if (hcnt_inc > (wide_mode ? 5'd16 : 5'd8)) begin
                            b_err = ilp_pkg::ST_RANGE;
                        end
                    end
                end
                default: begin
                    if (acc_reg > ilp_pkg::DEC_LIM10[lim_idx] ||
                        acc10 > ilp_pkg::DEC_LIM[lim_idx] - 64'(dval)) begin
                        b_err = ilp_pkg::ST_RANGE;
                    end else begin
                        b_acc = acc10 + 64'(dval);
                    end
                end
            endcase
        end
    end

    // top-level character dispatch
    always_comb begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        neg_next   = neg_reg;
        radix_next = radix_reg;
        hcnt_next  = hcnt_reg;
        sfx_next   = sfx_reg;
        space_next = space_reg;
        nz_next    = nz_reg;
        err_next   = err_reg;
        body_radix = radix_reg;
        body_en    = 1'b0;
        if (err_reg == ilp_pkg::ST_OK) begin
            if (is_blank) begin
                if (phase_reg != PH_LEAD) begin
                    space_next = 1'b1;
                end
            end else if (phase_reg == PH_LEAD) begin
                if (i_char_reg == CH_ZERO) begin
                    phase_next = PH_ZERO;
                end else if (i_char_reg == CH_PLUS || i_char_reg == CH_MINUS) begin
                    neg_next   = (i_char_reg == CH_MINUS);
                    phase_next = PH_SIGN_EMPTY;
                end else begin
                    phase_next = PH_BODY;
                    radix_next = RX_DEC;
                    body_radix = RX_DEC;
                    body_en    = 1'b1;
                end
            end else if (space_reg) begin
                err_next = ilp_pkg::ST_FORMAT;
            end else if (phase_reg == PH_ZERO) begin
                if (i_char_reg == CH_X) begin
                    radix_next = RX_HEX;
                    phase_next = PH_HEX_EMPTY;
                end else begin
                    radix_next = RX_OCT;
                    phase_next = PH_BODY;
                    body_radix = RX_OCT;
                    body_en    = 1'b1;
                end
            end else begin
                phase_next = PH_BODY;
                body_en    = 1'b1;
            end
        end
        if (body_en) begin
            acc_next  = b_acc;
            hcnt_next = b_hcnt;
            sfx_next  = b_sfx;
            nz_next   = b_nz;
            err_next  = b_err;
        end
    end

    // finished literal record
    always_comb begin
        f_next.mag    = acc_next;
        f_next.status = err_next;
        if (err_next == ilp_pkg::ST_OK &&
            (phase_next == PH_LEAD || phase_next == PH_HEX_EMPTY ||
             phase_next == PH_SIGN_EMPTY)) begin
            f_next.status = ilp_pkg::ST_FORMAT;
        end
        f_next.is_dec = (phase_next == PH_BODY) && (radix_next == RX_DEC);
        f_next.neg    = neg_next;
        f_next.sfx    = sfx_next;
        f_next.wide   = wide_mode;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            i_valid_reg <= 1'b0;
            f_valid_reg <= 1'b0;
            phase_reg   <= PH_LEAD;
            acc_reg     <= 64'd0;
            neg_reg     <= 1'b0;
            radix_reg   <= RX_DEC;
            hcnt_reg    <= 5'd0;
            sfx_reg     <= SFX_NONE;
            space_reg   <= 1'b0;
            nz_reg      <= 1'b0;
            err_reg     <= ilp_pkg::ST_OK;
        end else begin
            if (s_tvalid && s_tready) begin
                i_valid_reg <= 1'b1;
            end else if (proc) begin
                i_valid_reg <= 1'b0;
            end
            if (proc && i_last_reg) begin
                f_valid_reg <= 1'b1;
            end else if (fin_ready) begin
                f_valid_reg <= 1'b0;
            end
            if (proc) begin
                if (i_last_reg) begin
                    phase_reg <= PH_LEAD;
                    acc_reg   <= 64'd0;
                    neg_reg   <= 1'b0;
                    radix_reg <= RX_DEC;
                    hcnt_reg  <= 5'd0;
                    sfx_reg   <= SFX_NONE;
                    space_reg <= 1'b0;
                    nz_reg    <= 1'b0;
                    err_reg   <= ilp_pkg::ST_OK;
                end else begin
                    phase_reg <= phase_next;
                    acc_reg   <= acc_next;
                    neg_reg   <= neg_next;
                    radix_reg <= radix_next;
                    hcnt_reg  <= hcnt_next;
                    sfx_reg   <= sfx_next;
                    space_reg <= space_next;
                    nz_reg    <= nz_next;
                    err_reg   <= err_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            i_char_reg <= s_tdata;
            i_last_reg <= s_tlast;
        end
        if (proc && i_last_reg) begin
            f_reg <= f_next;
        end
    end

endmodule
`default_nettype wire

// ----- hdl/ilp_scale.sv -----
// suffix range check, split suffix multiply, sign and width forming, output register
`default_nettype none
module ilp_scale (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          fin_valid,
    output logic               fin_ready,
    input  wire ilp_pkg::fin_t fin,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [63:0]        m_tdata,
    output logic [1:0]         m_tuser
);

    // product stage
    logic             p_valid_reg;
    logic [61:0]      p0_reg;
    logic [31:0]      p1_reg;
    ilp_pkg::status_t p_status_reg;
    logic             p_neg_reg;
    logic             p_wide_reg;

    // output register
    logic             o_valid_reg;
    logic [63:0]      o_value_reg;
    ilp_pkg::status_t o_status_reg;

    logic o_free;
    logic p_free;

    assign o_free    = !o_valid_reg || m_tready;
    assign p_free    = !p_valid_reg || o_free;
    assign fin_ready = p_free;
    assign m_tvalid  = o_valid_reg;
    assign m_tdata   = o_value_reg;
    assign m_tuser   = o_status_reg;

    logic [63:0]      fac;
    logic             use_fac;
    logic [30:0]      mult;
    logic [61:0]      p0_next;
    logic [61:0]      p1_full;
    ilp_pkg::status_t p_status_next;

    always_comb begin
        fac     = ilp_pkg::FACTOR_TAB[fin.sfx];
        use_fac = fin.is_dec && (fac != 64'd0);
        // largest factor is 2^30, so 31 bits hold every suffix
        mult    = use_fac ? fac[30:0] : 31'd1;
        p0_next = 62'(fin.mag[31:0]) * 62'(mult);
        p1_full = 62'(fin.mag[63:32]) * 62'(mult);
        p_status_next = fin.status;
        if (fin.status == ilp_pkg::ST_OK && use_fac &&
            fin.mag > ilp_pkg::SFX_LIM[{fin.wide, fin.neg}][fin.sfx]) begin
            p_status_next = ilp_pkg::ST_RANGE;
        end
    end

    logic [63:0] mag;
    logic [63:0] signed_val;
    logic [63:0] o_value_next;

    always_comb begin
        mag        = 64'(p0_reg) + {p1_reg, 32'd0};
        signed_val = p_neg_reg ? (64'd0 - mag) : mag;
        if (p_status_reg != ilp_pkg::ST_OK) begin
            o_value_next = 64'd0;
        end else if (!p_wide_reg) begin
            o_value_next = {{32{signed_val[31]}}, signed_val[31:0]};
        end else begin
            o_value_next = signed_val;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end else begin
            if (p_free) begin
                p_valid_reg <= fin_valid;
            end
            if (o_free) begin
                o_valid_reg <= p_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (p_free && fin_valid) begin
            p0_reg       <= p0_next;
            p1_reg       <= p1_full[31:0];
            p_status_reg <= p_status_next;
            p_neg_reg    <= fin.is_dec && fin.neg;
            p_wide_reg   <= fin.wide;
        end
        if (o_free && p_valid_reg) begin
            o_value_reg  <= o_value_next;
            o_status_reg <= p_status_reg;
        end
    end

endmodule
`default_nettype wire

// ----- hdl/integer_literal_parser_core.sv -----
// top level of the integer literal parser: config register and stream pipeline
`default_nettype none
// Parses a text integer literal streamed one character per word (tlast on the
// final character) and returns one word per literal: the value on m_tdata and
// the status (0 ok, 1 bad format, 2 out of range) on m_tuser. Characters are
// taken one per cycle, stalling only while a final character waits for a free
// finished-literal register. m_tvalid rises once a literal has passed the
// input register, the parser's finished-literal register and the split 32-bit
// suffix multiplier's product register; the output register then holds the
// word until it is taken. Those stages also buffer up to three finished results
// so input keeps flowing while the output side stalls. wide_mode (address 0)
// selects 64-bit limits when set, 32-bit limits sign-extended to 64 when clear.
module integer_literal_parser_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // stream in
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] char_code
    input  wire logic        s_tlast,
    // stream out
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,   // [63:0] parsed_value
    output logic [1:0]       m_tuser,   // [1:0] status
    output logic             m_tlast,
    // config
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam logic REG_WIDE_MODE = 1'b0;

    logic wide_reg;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_WIDE_MODE) ? {31'd0, wide_reg} : 32'd0;
    assign m_tlast = m_tvalid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wide_reg <= 1'b0;
        end else if (psel && penable && pwrite && pready &&
                     paddr[2] == REG_WIDE_MODE) begin
            wide_reg <= pwdata[0];
        end
    end

    logic          fin_valid;
    logic          fin_ready;
    ilp_pkg::fin_t fin;

    ilp_parse u_parse (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .wide_mode (wide_reg),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .fin_valid (fin_valid),
        .fin_ready (fin_ready),
        .fin       (fin)
    );

    ilp_scale u_scale (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fin_valid (fin_valid),
        .fin_ready (fin_ready),
        .fin       (fin),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule
`default_nettype wire
